[rtl/radar_frame_polar_to_cartesian_defines.svh]
// Assertion macros for the radar frame polar to cartesian block.
// Taken in by the top level only; no other dependencies.
`ifndef RADAR_FRAME_POLAR_TO_CARTESIAN_DEFINES_SVH
`define RADAR_FRAME_POLAR_TO_CARTESIAN_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define RFPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfpc assertion failed");

// Next-cycle implication, disabled while in reset
`define RFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfpc assertion failed");

`endif

[rtl/rfpc_pkg.sv]
// Shared constants, types and the arctangent table for the radar frame converter.
// No dependencies; used by every module of the block.
package rfpc_pkg;

	// Frame layout
	localparam int FRAME_BYTES = 16;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int HDR_BYTES   = 8;

	// CORDIC
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam int STEP_W       = $clog2(CORDIC_ITERS);

	// Configuration register indexes
	localparam logic CFG_SENSOR  = 1'b0;
	localparam logic CFG_RCS_THR = 1'b1;

	localparam logic signed [16:0] RCS_THR_RESET  = -17'sd100;
	localparam logic [31:0]        TRACK_ID_START = 32'd2000;

	// Result bus width: 155 bits of fields padded to whole bytes
	localparam int RES_BITS  = 155;
	localparam int TDATA_W   = ((RES_BITS + 7) / 8) * 8;

	// Raw frame words
	typedef struct packed {
		logic [15:0] range_w;
		logic [15:0] angle_w;
		logic [15:0] speed_w;
		logic [15:0] rcs_w;
	} frame_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              launch;
		logic              calc_quo;
		logic              calc_bear;
		logic              calc_fold;
		logic              calc_zmul;
		logic              calc_zdiv;
		logic              calc_zsum;
		logic              rot_step;
		logic              calc_round;
		logic              load_out;
		logic [STEP_W-1:0] step;
	} cmd_t;

	// atan(2^-i) as binary angle, 2^32 per turn
	function automatic logic [29:0] atan_bin(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/rfpc_framer.sv]
// Byte framer: counts link bytes within a frame and keeps the eight header bytes.
// Depends on rfpc_pkg.
module rfpc_framer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	output logic                 at_last,
	output logic                 frame_done,
	output rfpc_pkg::frame_t     frame
);

	logic [rfpc_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                 hdr_q [rfpc_pkg::HDR_BYTES];
	logic [7:0]                 hdr_nxt [rfpc_pkg::HDR_BYTES];
	logic                       in_hdr;

	assign at_last    = (idx_q == rfpc_pkg::IDX_W'(rfpc_pkg::FRAME_BYTES - 1));
	assign frame_done = accept && at_last;
	assign in_hdr     = ({1'b0, idx_q} < (rfpc_pkg::IDX_W + 1)'(rfpc_pkg::HDR_BYTES));

	// Position within the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			if (at_last) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Header bytes; later bytes of the frame are dropped
	always_ff @(posedge clk) begin
		if (accept && in_hdr) begin
			hdr_q[idx_q[2:0]] <= rx_byte;
		end
	end

	// Header as it stands after this cycle's byte, so the last byte is seen at once
	always_comb begin
		for (int k = 0; k < rfpc_pkg::HDR_BYTES; k++) begin
			hdr_nxt[k] = (accept && in_hdr && (idx_q[2:0] == 3'(k))) ? rx_byte : hdr_q[k];
		end
	end

	assign frame.range_w = {hdr_nxt[0], hdr_nxt[1]};
	assign frame.angle_w = {hdr_nxt[2], hdr_nxt[3]};
	assign frame.speed_w = {hdr_nxt[4], hdr_nxt[5]};
	assign frame.rcs_w   = {hdr_nxt[6], hdr_nxt[7]};

endmodule

[rtl/rfpc_ctrl.sv]
// Sequencer for the track computation: angle reduction, CORDIC steps, output hand-off.
// Depends on rfpc_pkg.
module rfpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_done,
	input  logic                 out_ready,
	output logic                 busy,
	output logic                 out_valid,
	output rfpc_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QUO,
		ST_BEAR,
		ST_FOLD,
		ST_ZMUL,
		ST_ZDIV,
		ST_ZSUM,
		ST_ROT,
		ST_ROUND,
		ST_OUT
	} state_t;

	localparam logic [rfpc_pkg::STEP_W-1:0] STEP_LAST =
		rfpc_pkg::STEP_W'(rfpc_pkg::CORDIC_ITERS - 1);

	state_t                      state_q;
	logic [rfpc_pkg::STEP_W-1:0] step_q;
	logic                        out_valid_q;
	logic                        load_ok;

	assign load_ok   = !out_valid_q || out_ready;
	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.launch     = (state_q == ST_IDLE) && frame_done;
		cmd.calc_quo   = (state_q == ST_QUO);
		cmd.calc_bear  = (state_q == ST_BEAR);
		cmd.calc_fold  = (state_q == ST_FOLD);
		cmd.calc_zmul  = (state_q == ST_ZMUL);
		cmd.calc_zdiv  = (state_q == ST_ZDIV);
		cmd.calc_zsum  = (state_q == ST_ZSUM);
		cmd.rot_step   = (state_q == ST_ROT);
		cmd.calc_round = (state_q == ST_ROUND);
		cmd.load_out   = (state_q == ST_OUT) && load_ok;
		cmd.step       = step_q;
	end

	// State, step counter and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Valid set on hand-off, cleared once the transaction is taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (frame_done) begin
						state_q <= ST_QUO;
					end
				end
				ST_QUO:   state_q <= ST_BEAR;
				ST_BEAR:  state_q <= ST_FOLD;
				ST_FOLD:  state_q <= ST_ZMUL;
				ST_ZMUL:  state_q <= ST_ZDIV;
				ST_ZDIV:  state_q <= ST_ZSUM;
				ST_ZSUM: begin
					step_q  <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (step_q == STEP_LAST) begin
						step_q  <= '0;
						state_q <= ST_ROUND;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROUND: state_q <= ST_OUT;
				ST_OUT: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/rfpc_dp.sv]
// Datapath: frame snapshot, bearing reduction, binary angle, CORDIC rotation, result register.
// Depends on rfpc_pkg; driven by rfpc_ctrl.
module rfpc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rfpc_pkg::cmd_t       cmd,
	input  rfpc_pkg::frame_t     frame,
	input  logic [15:0]          sensor_number,
	input  logic signed [16:0]   rcs_threshold,
	output logic [31:0]          track_number,
	output logic [15:0]          range_raw,
	output logic signed [11:0]   bearing_tenths,
	output logic [15:0]          speed_raw,
	output logic [15:0]          rcs_raw,
	output logic signed [16:0]   x_pos,
	output logic signed [16:0]   y_pos,
	output logic signed [11:0]   heading_tenths,
	output logic                 confidence_high,
	output logic [15:0]          sensor_out
);

	localparam logic [32:0] MOD_RECIP  = 33'd74566;     // ceil(2^28 / 3600)
	localparam logic [48:0] GAIN_Q30   = 49'd652032874;
	localparam logic [30:0] Z_INT      = 31'd1193046;   // 2^28 div 225
	localparam logic [34:0] DIV225_REC = 35'd149131;    // ceil(2^25 / 225)

	logic [31:0]        next_track_q;
	logic [31:0]        track_q;
	logic [15:0]        range_q, angle_q, speed_q, rcs_q;
	logic [4:0]         quo_q;
	logic signed [11:0] bearing_q;
	logic               flip_q, neg_q;
	logic [9:0]         mag_q;
	logic [30:0]        zbase_q;
	logic [16:0]        znum_q;
	logic [8:0]         zfrac_q;
	logic signed [32:0] z_q;
	logic signed [48:0] x_q, y_q;
	logic signed [18:0] xr_q, yr_q;

	logic [32:0]        quo_prod;
	logic [16:0]        rem_w;
	logic signed [12:0] bear_w;
	logic signed [11:0] fold_w;
	logic [34:0]        zdiv_prod;
	logic [30:0]        zmag;
	logic signed [48:0] dx, dy, xs, ys;
	logic signed [32:0] dz;

	function automatic logic signed [16:0] clamp_pos(input logic signed [18:0] v);
		logic signed [16:0] r;
		if (v > 19'sd65535) begin
			r = 17'sd65535;
		end else if (v < -19'sd65535) begin
			r = -17'sd65535;
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

	// Angle reduction arithmetic
	assign quo_prod  = 33'(angle_q) * MOD_RECIP;
	assign rem_w     = 17'(angle_q) - 17'(17'(quo_q) * 17'd3600);
	assign bear_w    = $signed({1'b0, rem_w[11:0]}) - 13'sd1800;
	assign fold_w    = (bearing_q > 12'sd900) ? bearing_q - 12'sd1800 :
		(bearing_q < -12'sd900) ? bearing_q + 12'sd1800 : bearing_q;
	assign zdiv_prod = 35'(znum_q) * DIV225_REC;
	assign zmag      = zbase_q + 31'(zfrac_q);

	// One CORDIC rotation
	assign dx = y_q >>> cmd.step;
	assign dy = x_q >>> cmd.step;
	assign dz = $signed({3'b000, rfpc_pkg::atan_bin(5'(cmd.step))});

	// Round half up to 0.1 m
	assign xs = x_q + 49'sd536870912;
	assign ys = y_q + 49'sd536870912;

	// Running track number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_track_q <= rfpc_pkg::TRACK_ID_START;
		end else if (cmd.launch) begin
			next_track_q <= next_track_q + 32'd1;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			track_q <= next_track_q;
			range_q <= frame.range_w;
			angle_q <= frame.angle_w;
			speed_q <= frame.speed_w;
			rcs_q   <= frame.rcs_w;
		end
		if (cmd.calc_quo) begin
			quo_q <= quo_prod[32:28];
			x_q   <= $signed(49'(range_q) * GAIN_Q30);
			y_q   <= '0;
		end
		if (cmd.calc_bear) begin
			bearing_q <= bear_w[11:0];
		end
		if (cmd.calc_fold) begin
			flip_q <= (bearing_q > 12'sd900) || (bearing_q < -12'sd900);
			neg_q  <= fold_w[11];
			mag_q  <= fold_w[11] ? 10'(-fold_w) : fold_w[9:0];
		end
		if (cmd.calc_zmul) begin
			zbase_q <= 31'(mag_q) * Z_INT;
			znum_q  <= 17'(17'(mag_q) * 17'd106 + 17'd112);
		end
		if (cmd.calc_zdiv) begin
			zfrac_q <= zdiv_prod[33:25];
		end
		if (cmd.calc_zsum) begin
			z_q <= neg_q ? -$signed(33'(zmag)) : $signed(33'(zmag));
		end
		if (cmd.rot_step) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - dz;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + dz;
			end
		end
		if (cmd.calc_round) begin
			xr_q <= flip_q ? -xs[48:30] : xs[48:30];
			yr_q <= flip_q ? -ys[48:30] : ys[48:30];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			track_number    <= track_q;
			range_raw       <= range_q;
			bearing_tenths  <= bearing_q;
			speed_raw       <= speed_q;
			rcs_raw         <= rcs_q;
			x_pos           <= clamp_pos(xr_q);
			y_pos           <= clamp_pos(yr_q);
			heading_tenths  <= (range_q == 16'd0) ? 12'sd0 : bearing_q;
			confidence_high <= ($signed({1'b0, rcs_q}) > rcs_threshold);
			sensor_out      <= sensor_number;
		end
	end

endmodule

[rtl/radar_frame_polar_to_cartesian.sv]
// When a frame's last byte is accepted, the sequencer runs quotient, bearing, fold,
// z terms, CORDIC rotations and rounding, then hands the track to the output.
// Throughput: one link byte per cycle; the last byte of the next frame waits until the
// sequencer is idle, set by the single CORDIC unit doing one rotation per cycle.
// Reset (arst_n, asynchronous, active low): frame position 0, track id 2000,
// sensor number 0, RCS threshold -100, no track pending.
module radar_frame_polar_to_cartesian (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // rx_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// track_number, range_raw, bearing_tenths, speed_raw, rcs_raw, x_pos, y_pos,
	// heading_tenths, confidence_high, sensor_out, zero padding
	output logic [rfpc_pkg::TDATA_W-1:0]   m_axis_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [16:0]                    cfg_data
);

	`include "radar_frame_polar_to_cartesian_defines.svh"

	logic               accept;
	logic               at_last;
	logic               frame_done;
	logic               busy;
	rfpc_pkg::frame_t   frame;
	rfpc_pkg::cmd_t     cmd;

	logic [15:0]        sensor_q;
	logic signed [16:0] rcs_thr_q;

	logic [31:0]        track_number;
	logic [15:0]        range_raw, speed_raw, rcs_raw, sensor_out;
	logic signed [11:0] bearing_tenths, heading_tenths;
	logic signed [16:0] x_pos, y_pos;
	logic               confidence_high;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_q  <= '0;
			rcs_thr_q <= rfpc_pkg::RCS_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rfpc_pkg::CFG_SENSOR:  sensor_q  <= cfg_data[15:0];
				rfpc_pkg::CFG_RCS_THR: rcs_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off only the byte that would complete a frame while the last one is in work
	assign s_axis_tready = !(at_last && busy);
	assign accept        = s_axis_tvalid && s_axis_tready;

	rfpc_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (s_axis_tdata),
		.at_last    (at_last),
		.frame_done (frame_done),
		.frame      (frame)
	);

	rfpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_done (frame_done),
		.out_ready  (m_axis_tready),
		.busy       (busy),
		.out_valid  (m_axis_tvalid),
		.cmd        (cmd)
	);

	rfpc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.frame           (frame),
		.sensor_number   (sensor_q),
		.rcs_threshold   (rcs_thr_q),
		.track_number    (track_number),
		.range_raw       (range_raw),
		.bearing_tenths  (bearing_tenths),
		.speed_raw       (speed_raw),
		.rcs_raw         (rcs_raw),
		.x_pos           (x_pos),
		.y_pos           (y_pos),
		.heading_tenths  (heading_tenths),
		.confidence_high (confidence_high),
		.sensor_out      (sensor_out)
	);

	// Pack the track, first field in the lowest bits
	assign m_axis_tdata = {
		(rfpc_pkg::TDATA_W - rfpc_pkg::RES_BITS)'(0),
		sensor_out,
		confidence_high,
		heading_tenths,
		y_pos,
		x_pos,
		rcs_raw,
		speed_raw,
		bearing_tenths,
		range_raw,
		track_number
	};

	// A completed frame always starts the sequencer
	`RFPC_ASSERT_NEXT(a_launch_busy, clk, arst_n, frame_done, busy)
	// Sequencer only returns to idle having handed over a track
	`RFPC_ASSERT_NOW(a_done_valid, clk, arst_n, $fell(busy), m_axis_tvalid)
	// Input is held off only while a track is in work
	`RFPC_ASSERT_NOW(a_stall_busy, clk, arst_n, !s_axis_tready, busy && at_last)

endmodule

[dv/radar_frame_polar_to_cartesian_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for radar_frame_polar_to_cartesian: link bytes in, decoded tracks out.
// Depends on rfpc_pkg and the block itself; the frame decoder and CORDIC are predicted here.
module radar_frame_polar_to_cartesian_tb;

	localparam int FRAME_LEN   = rfpc_pkg::FRAME_BYTES;
	localparam int HDR_LEN     = 8;
	localparam int ROT_STEPS   = (rfpc_pkg::CORDIC_STEPS > 24) ? 24 : rfpc_pkg::CORDIC_STEPS;
	localparam int SETTLE      = 40;      // margin beyond the track latency
	localparam int CYCLE_LIMIT = 250000;

	localparam longint GAIN_Q30  = 64'sd652032874;
	localparam longint XY_LIMIT  = 64'sd65535;
	localparam longint TURN_BIN  = 64'sd4294967296;

	// atan(2^-i), binary angle with 2^32 per turn
	localparam longint ATAN_TAB [0:23] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304,
		652, 326, 163, 81
	};

	// bearings at and around the fold points
	localparam int EDGE_BEARINGS [0:8] = '{-1800, -901, -900, -899, 0, 899, 900, 901, 1799};

	// One track as it sits on m_axis_tdata, lowest field last
	typedef struct packed {
		logic [15:0] sensor_out;
		logic        confidence_high;
		logic [11:0] heading_tenths;
		logic [16:0] y_pos;
		logic [16:0] x_pos;
		logic [15:0] rcs_raw;
		logic [15:0] speed_raw;
		logic [11:0] bearing_tenths;
		logic [15:0] range_raw;
		logic [31:0] track_number;
	} track_t;

	// Track predictor and scoreboard
	class track_scoreboard;
		int          frame_pos = 0;
		logic [7:0]  hdr_bytes [HDR_LEN];
		logic [31:0] next_id = rfpc_pkg::TRACK_ID_START;
		logic [15:0] radar_tag = '0;
		int          rcs_limit = -100;
		track_t      pending_tracks [$];
		int          mismatches = 0;
		int          tracks_checked = 0;
		int          bytes_seen = 0;

		function void set_register(logic idx, logic [16:0] value);
			if (idx == rfpc_pkg::CFG_SENSOR) begin
				radar_tag = value[15:0];
			end else begin
				rcs_limit = int'($signed(value));
			end
		endfunction

		// CORDIC rotation of (range, 0) by the bearing, folded into +/-90 degrees
		function void rotate(logic [15:0] rng, int brg, output longint xo, output longint yo);
			int     a;
			bit     flip;
			longint mag, z, x, y, dx, dy;
			a = brg;
			flip = 1'b0;
			if (a > 900) begin
				a -= 1800;
				flip = 1'b1;
			end else if (a < -900) begin
				a += 1800;
				flip = 1'b1;
			end
			mag = (a < 0) ? -longint'(a) : longint'(a);
			z = (mag * TURN_BIN + 1800) / 3600;
			if (a < 0)
				z = -z;
			x = longint'({48'b0, rng}) * GAIN_Q30;
			y = 0;
			for (int i = 0; i < ROT_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_TAB[i];
				end else begin
					x += dx; y -= dy; z += ATAN_TAB[i];
				end
			end
			x = (x + 64'sd536870912) >>> 30;
			y = (y + 64'sd536870912) >>> 30;
			if (flip) begin
				x = -x;
				y = -y;
			end
			xo = (x > XY_LIMIT) ? XY_LIMIT : (x < -XY_LIMIT) ? -XY_LIMIT : x;
			yo = (y > XY_LIMIT) ? XY_LIMIT : (y < -XY_LIMIT) ? -XY_LIMIT : y;
		endfunction

		function track_t predict_track();
			track_t t;
			logic [15:0] rng, ang, spd, rcs;
			int brg;
			longint x, y;
			rng = {hdr_bytes[0], hdr_bytes[1]};
			ang = {hdr_bytes[2], hdr_bytes[3]};
			spd = {hdr_bytes[4], hdr_bytes[5]};
			rcs = {hdr_bytes[6], hdr_bytes[7]};
			brg = int'(ang % 16'd3600) - 1800;
			rotate(rng, brg, x, y);
			t.track_number    = next_id;
			t.range_raw       = rng;
			t.bearing_tenths  = brg[11:0];
			t.speed_raw       = spd;
			t.rcs_raw         = rcs;
			t.x_pos           = x[16:0];
			t.y_pos           = y[16:0];
			t.heading_tenths  = (rng == 0) ? 12'd0 : brg[11:0];
			t.confidence_high = (int'({16'b0, rcs}) > rcs_limit);
			t.sensor_out      = radar_tag;
			return t;
		endfunction

		// accepted input transaction
		function void note_byte(logic [7:0] b);
			bytes_seen++;
			if (frame_pos < HDR_LEN)
				hdr_bytes[frame_pos] = b;
			if (frame_pos + 1 < FRAME_LEN) begin
				frame_pos++;
				return;
			end
			frame_pos = 0;
			pending_tracks.push_back(predict_track());
			next_id = next_id + 32'd1;
		endfunction

		function void compare(string field, longint want, longint got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		// accepted output transaction
		function void check_track(logic [rfpc_pkg::TDATA_W-1:0] bus);
			track_t got, want;
			got = track_t'(bus[$bits(track_t)-1:0]);
			if (pending_tracks.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected track, expected none, actual %h", $time, got);
				return;
			end
			want = pending_tracks.pop_front();
			tracks_checked++;
			compare("track_number", want.track_number, got.track_number);
			compare("range_raw", want.range_raw, got.range_raw);
			compare("bearing_tenths", $signed(want.bearing_tenths), $signed(got.bearing_tenths));
			compare("speed_raw", want.speed_raw, got.speed_raw);
			compare("rcs_raw", want.rcs_raw, got.rcs_raw);
			compare("x_pos", $signed(want.x_pos), $signed(got.x_pos));
			compare("y_pos", $signed(want.y_pos), $signed(got.y_pos));
			compare("heading_tenths", $signed(want.heading_tenths), $signed(got.heading_tenths));
			compare("confidence_high", want.confidence_high, got.confidence_high);
			compare("sensor_out", want.sensor_out, got.sensor_out);
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [7:0]                   s_axis_tdata = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [rfpc_pkg::TDATA_W-1:0] m_axis_tdata;
	logic                         cfg_we = 1'b0;
	logic                         cfg_index = rfpc_pkg::CFG_SENSOR;
	logic [16:0]                  cfg_data = '0;

	track_scoreboard sb;
	int burst_left = 0;
	int settings_used = 1;
	int cycle_count = 0;

	radar_frame_polar_to_cartesian DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 8 ns clock
	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Receiver: stall pattern changes mode after each window of random length
	int stall_mode = 0;
	int window_left = 0;
	int stall_tick = 0;
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_track(m_axis_tdata);
		if (window_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			window_left = $urandom_range(20, 80);
		end
		window_left--;
		stall_tick++;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= (stall_tick % 5) >= 2;
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// One link byte; bursts of random length with random gaps between
	task automatic send_byte(input logic [7:0] b);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_frame(input logic [15:0] rng, input logic [15:0] ang,
			input logic [15:0] spd, input logic [15:0] rcs);
		send_byte(rng[15:8]);
		send_byte(rng[7:0]);
		send_byte(ang[15:8]);
		send_byte(ang[7:0]);
		send_byte(spd[15:8]);
		send_byte(spd[7:0]);
		send_byte(rcs[15:8]);
		send_byte(rcs[7:0]);
		repeat (FRAME_LEN - HDR_LEN) send_byte(8'($urandom));
	endtask

	task automatic send_random_frame();
		logic [15:0] rng, ang, rcs;
		int t;
		case ($urandom_range(0, 7))
			0: rng = 16'd0;
			1: rng = 16'hFFFF;
			2, 3: rng = 16'($urandom_range(0, 100));
			default: rng = 16'($urandom);
		endcase
		if ($urandom_range(0, 2) == 0)
			ang = 16'(EDGE_BEARINGS[$urandom_range(0, 8)] + 1800 + 3600 * $urandom_range(0, 17));
		else
			ang = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			t = sb.rcs_limit + int'($urandom_range(0, 2)) - 1;
			rcs = (t < 0) ? 16'd0 : (t > 65535) ? 16'hFFFF : 16'(t);
		end else begin
			rcs = 16'($urandom);
		end
		send_frame(rng, ang, 16'($urandom), rcs);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_tracks.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [16:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	// Called only with the block idle and on a frame boundary
	task automatic set_config(input logic [15:0] sensor, input int thr);
		write_reg(rfpc_pkg::CFG_SENSOR, {1'b0, sensor});
		write_reg(rfpc_pkg::CFG_RCS_THR, 17'(thr));
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic random_phase(input int frames);
		for (int f = 0; f < frames; f++) begin
			send_random_frame();
			// occasionally hold off until every track is out
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		sb = new;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed frames under reset settings
		send_frame(16'd0, 16'd0, 16'd0, 16'd0);              // zero range, bearing -180
		send_frame(16'hFFFF, 16'd1800, 16'hFFFF, 16'hFFFF);  // max range ahead, saturates
		send_frame(16'hFFFF, 16'd2700, 16'd1, 16'd1);        // +90 degrees, no fold
		send_frame(16'd1000, 16'd2701, 16'd2, 16'd2);        // just past +90, folded
		send_frame(16'd40000, 16'd899, 16'd3, 16'd3);        // just past -90, folded
		send_frame(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000);  // largest angle word
		send_frame(16'd12345, 16'd5399, 16'h00FF, 16'h7FFF); // bearing +179.9
		drain();

		// Register extremes, then random settings
		set_config(16'hFFFF, 65535);
		random_phase(9);
		set_config(16'h0000, -100);
		random_phase(9);
		set_config(16'($urandom), int'($urandom_range(0, 65635)) - 100);
		random_phase(8);
		set_config(16'($urandom), int'($urandom_range(0, 400)) - 100);
		random_phase(8);

		$display("Sent %0d link bytes in %0d frames over %0d register settings",
			sb.bytes_seen, sb.bytes_seen / FRAME_LEN, settings_used);
		$display("Checked %0d tracks, %0d field mismatches", sb.tracks_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_tracks.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
